// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmpd_pkg.sv =====
// Types, codes and constants of the BMP stream decoder.
`timescale 1ns / 1ps
package bmpd_pkg;

  localparam int KIND_W = 2;
  localparam int ERR_W  = 3;
  localparam int RGB_W  = 24;
  localparam int ADDR_W = 24;
  localparam int DIM_W  = 13;

  localparam logic [31:0] LIMIT_RESET = 32'd16842752;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Byte offsets of the last byte of each header field
  localparam logic [31:0] POS_SIZE_END   = 32'd5;
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_BPP_END    = 32'd29;
  localparam logic [31:0] POS_COMP_END   = 32'd33;
  localparam logic [31:0] POS_RAW_END    = 32'd37;

  localparam logic [15:0] BPP_24 = 16'd24;
  localparam int DIV_STEPS = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 3'd0,
    ERR_LARGE  = 3'd1,
    ERR_ZERO   = 3'd2,
    ERR_BPP    = 3'd3,
    ERR_COMP   = 3'd4,
    ERR_RAW    = 3'd5,
    ERR_BOUNDS = 3'd6
  } err_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_SKIP   = 4'd1,
    PH_PIXEL  = 4'd2,
    PH_PAD    = 4'd3,
    PH_IDLE   = 4'd4,
    PH_MUL    = 4'd5,
    PH_NEED   = 4'd6,
    PH_CHK    = 4'd7,
    PH_DIV    = 4'd8,
    PH_HDR    = 4'd9
  } phase_t;

  typedef struct packed {
    logic  take;
    logic  restart;
    logic  hdr_byte;
    logic  pix_byte;
    logic  pad_byte;
    logic  mul;
    logic  need;
    logic  div_init;
    logic  div_step;
    logic  pix_init;
    logic  push;
    kind_t kind;
    err_t  err;
  } bmpd_cmd_t;

  typedef struct packed {
    logic chk_fail;
    err_t chk_code;
    logic at_raw;
    logic skip_done;
    logic pix_done;
    logic row_end;
    logic img_end;
    logic pad_nonzero;
    logic pad_last;
    logic raw_short;
    logic div_done;
  } bmpd_stat_t;

  typedef struct packed {
    kind_t             kind;
    err_t              err;
    logic [RGB_W-1:0]  rgb;
    logic [ADDR_W-1:0] addr;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              last;
  } bmpd_result_t;

endpackage

// ===== rtl/bmpd_in_if.sv =====
// Byte input channel.
`timescale 1ns / 1ps
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== rtl/bmpd_out_if.sv =====
// Result output channel.
`timescale 1ns / 1ps
interface bmpd_out_if import bmpd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [ERR_W-1:0]  error_code;
  logic [RGB_W-1:0]  pixel_rgb;
  logic [ADDR_W-1:0] pixel_address;
  logic [DIM_W-1:0]  out_width;
  logic [DIM_W-1:0]  out_height;
  logic              last_pixel;

  modport source (output valid, output result_kind, output error_code, output pixel_rgb,
                  output pixel_address, output out_width, output out_height,
                  output last_pixel, input ready);
  modport sink (input valid, input result_kind, input error_code, input pixel_rgb,
                input pixel_address, input out_width, input out_height,
                input last_pixel, output ready);
endinterface

// ===== rtl/bmpd_cfg_if.sv =====
// Configuration write channel for the file size limit.
`timescale 1ns / 1ps
interface bmpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_size_limit;

  modport source (output valid, output file_size_limit, input ready);
  modport sink (input valid, input file_size_limit, output ready);
endinterface

// ===== rtl/bmpd_ctrl.sv =====
// Phase controller: header parse, padding division sequence, pixel and pad phases.
`timescale 1ns / 1ps
module bmpd_ctrl import bmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_first,
  output logic       in_ready,
  input  logic       obuf_full,
  input  bmpd_stat_t stat,
  output bmpd_cmd_t  cmd
);

  phase_t phase;
  phase_t phase_next;
  phase_t phase_eff;
  phase_t pix_to;
  logic   take;

  assign in_ready = (phase inside {PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD, PH_IDLE}) &&
                    !obuf_full;
  assign take = in_valid && in_ready;
  // a first-byte mark restarts parsing with the current word
  assign phase_eff = in_first ? PH_HEADER : phase;

  always_comb begin
    pix_to = PH_PIXEL;
    if (stat.pix_done && stat.row_end) begin
      if (stat.img_end) begin
        pix_to = PH_IDLE;
      end else if (stat.pad_nonzero) begin
        pix_to = PH_PAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_MUL: phase_next = PH_NEED;
      PH_NEED: phase_next = PH_CHK;
      PH_CHK: begin
        if (!stat.raw_short) begin
          phase_next = PH_DIV;
        end else if (!obuf_full) begin
          phase_next = PH_IDLE;
        end
      end
      PH_DIV: begin
        if (stat.div_done) begin
          phase_next = PH_HDR;
        end
      end
      PH_HDR: begin
        if (!obuf_full) begin
          phase_next = PH_SKIP;
        end
      end
      default: begin
        if (take) begin
          case (phase_eff)
            PH_HEADER: begin
              if (stat.chk_fail) begin
                phase_next = PH_IDLE;
              end else if (stat.at_raw) begin
                phase_next = PH_MUL;
              end else begin
                phase_next = PH_HEADER;
              end
            end
            PH_SKIP: begin
              if (stat.skip_done) begin
                phase_next = pix_to;
              end
            end
            PH_PIXEL: phase_next = pix_to;
            PH_PAD: begin
              if (stat.pad_last) begin
                phase_next = PH_PIXEL;
              end
            end
            default: phase_next = phase_eff;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.kind = KIND_PIXEL;
    cmd.err = ERR_NONE;
    cmd.take = take;
    cmd.restart = take && in_first;
    case (phase)
      PH_MUL: cmd.mul = 1'b1;
      PH_NEED: cmd.need = 1'b1;
      PH_CHK: begin
        if (!stat.raw_short) begin
          cmd.div_init = 1'b1;
        end else if (!obuf_full) begin
          cmd.push = 1'b1;
          cmd.kind = KIND_ERROR;
          cmd.err = ERR_RAW;
        end
      end
      PH_DIV: cmd.div_step = 1'b1;
      PH_HDR: begin
        if (!obuf_full) begin
          cmd.push = 1'b1;
          cmd.kind = KIND_HEADER;
          cmd.pix_init = 1'b1;
        end
      end
      default: begin
        if (take) begin
          case (phase_eff)
            PH_HEADER: begin
              cmd.hdr_byte = 1'b1;
              if (stat.chk_fail) begin
                cmd.push = 1'b1;
                cmd.kind = KIND_ERROR;
                cmd.err = stat.chk_code;
              end
            end
            PH_SKIP: begin
              if (stat.skip_done) begin
                cmd.pix_byte = 1'b1;
                cmd.push = stat.pix_done;
              end
            end
            PH_PIXEL: begin
              cmd.pix_byte = 1'b1;
              cmd.push = stat.pix_done;
            end
            PH_PAD: cmd.pad_byte = 1'b1;
            default: cmd.pix_byte = 1'b0;
          endcase
        end
      end
    endcase
  end

endmodule

// ===== rtl/bmpd_datapath.sv =====
// Header field registers, checks, area multiply, padding divider, pixel counters.
`timescale 1ns / 1ps
module bmpd_datapath import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   data_byte,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_data,
  input  bmpd_cmd_t    cmd,
  output bmpd_stat_t   stat,
  output bmpd_result_t result
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = WW + HW;
  localparam int NW  = PW + 2;
  localparam int CW  = (NW > 32) ? NW : 32;
  localparam int DCW = $clog2(DIV_STEPS);

  logic [31:0]    file_size_limit;
  logic [31:0]    byte_position;
  logic [31:0]    field_shift;
  logic [31:0]    data_offset;
  logic [WW-1:0]  width_reg;
  logic [HW-1:0]  height_reg;
  logic [31:0]    raw_image_size;
  logic [7:0]     row_padding;
  logic [HW-1:0]  row_count;
  logic [WW-1:0]  column_count;
  logic [1:0]     byte_in_pixel;
  logic [15:0]    partial_pixel;
  logic [7:0]     padding_left;
  logic [PW-1:0]  area;
  logic [NW-1:0]  need;
  logic [PW-1:0]  row_base;
  logic [HW-1:0]  div_rem;
  logic [31:0]    div_dvd;
  logic [7:0]     div_quot;
  logic [DCW-1:0] div_cnt;

  logic [31:0]    pos_cur;
  logic [31:0]    fs_cur;
  logic [31:0]    field;
  logic [HW:0]    rem_sh;
  logic           rem_ge;
  logic [HW:0]    rem_sub;

  assign pos_cur = cmd.restart ? '0 : byte_position;
  assign fs_cur  = cmd.restart ? '0 : field_shift;
  // little-endian field: newest word lands in the top byte
  assign field   = {data_byte, fs_cur[31:8]};

  // header checks in file order
  always_comb begin
    stat.at_raw      = (pos_cur == POS_RAW_END);
    stat.skip_done   = (pos_cur >= data_offset);
    stat.pix_done    = (byte_in_pixel == 2'd2);
    stat.row_end     = (column_count == width_reg - WW'(1));
    stat.img_end     = (row_count == height_reg - HW'(1));
    stat.pad_nonzero = (row_padding != 8'd0);
    stat.pad_last    = (padding_left <= 8'd1);
    stat.raw_short   = (CW'(need) > CW'(raw_image_size));
    stat.div_done    = (div_cnt == DCW'(DIV_STEPS - 1));
    stat.chk_fail = 1'b0;
    stat.chk_code = ERR_NONE;
    if (pos_cur == POS_SIZE_END) begin
      if (field >= file_size_limit) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_LARGE;
      end
    end else if (pos_cur == POS_WIDTH_END) begin
      if (field == '0) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_ZERO;
      end else if (field > 32'(MAX_WIDTH)) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_BOUNDS;
      end
    end else if (pos_cur == POS_HEIGHT_END) begin
      if (field == '0) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_ZERO;
      end else if (field > 32'(MAX_HEIGHT)) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_BOUNDS;
      end
    end else if (pos_cur == POS_BPP_END) begin
      if (field[31:16] != BPP_24) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_BPP;
      end
    end else if (pos_cur == POS_COMP_END) begin
      if (field != '0) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_COMP;
      end
    end else if (pos_cur == POS_RAW_END) begin
      if (field[1:0] != 2'b00) begin
        stat.chk_fail = 1'b1;
        stat.chk_code = ERR_RAW;
      end
    end
  end

  // one restoring division step per cycle
  assign rem_sh  = {div_rem, div_dvd[31]};
  assign rem_ge  = (rem_sh >= {1'b0, height_reg});
  assign rem_sub = rem_sh - {1'b0, height_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      file_size_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      field_shift   <= '0;
    end else if (cmd.take) begin
      byte_position <= (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;
      field_shift   <= field;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_byte) begin
      if (pos_cur == POS_OFFSET_END) begin
        data_offset <= field;
      end
      if (pos_cur == POS_WIDTH_END) begin
        width_reg <= WW'(field);
      end
      if (pos_cur == POS_HEIGHT_END) begin
        height_reg <= HW'(field);
      end
      if (pos_cur == POS_RAW_END) begin
        raw_image_size <= field;
      end
    end
    if (cmd.mul) begin
      area <= PW'(width_reg) * PW'(height_reg);
    end
    if (cmd.need) begin
      need <= NW'({area, 1'b0}) + NW'(area);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_dvd  <= raw_image_size - 32'(need);
      div_rem  <= '0;
      div_quot <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      div_dvd  <= {div_dvd[30:0], 1'b0};
      div_rem  <= rem_ge ? HW'(rem_sub) : HW'(rem_sh);
      div_quot <= {div_quot[6:0], rem_ge};
      div_cnt  <= div_cnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_pixel <= '0;
      row_count     <= '0;
      column_count  <= '0;
      padding_left  <= '0;
      row_padding   <= '0;
    end else if (cmd.pix_init) begin
      row_padding   <= div_quot;
      row_base      <= area - PW'(width_reg);
      byte_in_pixel <= '0;
      partial_pixel <= '0;
      row_count     <= '0;
      column_count  <= '0;
      padding_left  <= '0;
    end else if (cmd.pix_byte) begin
      if (!stat.pix_done) begin
        if (byte_in_pixel == 2'd0) begin
          partial_pixel <= {8'd0, data_byte};
        end else begin
          partial_pixel <= {data_byte, partial_pixel[7:0]};
        end
        byte_in_pixel <= byte_in_pixel + 2'd1;
      end else begin
        byte_in_pixel <= '0;
        partial_pixel <= '0;
        if (stat.row_end) begin
          column_count <= '0;
          row_count    <= row_count + HW'(1);
          row_base     <= row_base - PW'(width_reg);
          padding_left <= row_padding;
        end else begin
          column_count <= column_count + WW'(1);
        end
      end
    end else if (cmd.pad_byte) begin
      if (padding_left != 8'd0) begin
        padding_left <= padding_left - 8'd1;
      end
    end
  end

  always_comb begin
    result = '0;
    result.kind = cmd.kind;
    result.err = cmd.err;
    case (cmd.kind)
      KIND_PIXEL: begin
        result.rgb  = {data_byte, partial_pixel};
        result.addr = ADDR_W'(row_base + PW'(column_count));
        result.last = stat.row_end && stat.img_end;
      end
      KIND_HEADER: begin
        result.width  = DIM_W'(width_reg);
        result.height = DIM_W'(height_reg);
      end
      default: result.last = 1'b0;
    endcase
  end

endmodule

// ===== rtl/bmpd_obuf.sv =====
// Two-entry output buffer between the decoder and the result channel.
`timescale 1ns / 1ps
module bmpd_obuf import bmpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmpd_result_t       push_data,
  output logic               full,
  bmpd_out_if.source         out
);

  bmpd_result_t head;
  bmpd_result_t spare;
  logic         head_valid;
  logic         spare_valid;
  logic         pop;

  assign pop  = head_valid && out.ready;
  assign full = spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        head        <= spare;
        spare_valid <= push;
        spare       <= push_data;
      end else begin
        head_valid <= push;
        head       <= push_data;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
        head       <= push_data;
      end else begin
        spare_valid <= 1'b1;
        spare       <= push_data;
      end
    end
  end

  assign out.valid         = head_valid;
  assign out.result_kind   = head.kind;
  assign out.error_code    = head.err;
  assign out.pixel_rgb     = head.rgb;
  assign out.pixel_address = head.addr;
  assign out.out_width     = head.width;
  assign out.out_height    = head.height;
  assign out.last_pixel    = head.last;

endmodule

// ===== rtl/bmp24_stream_decoder_top.sv =====
// Top level of the streaming 24-bit BMP decoder.
//
//  channel     dir  words                      payload
//  byte_in     in   one file byte each         data_byte, first_byte
//  result_out  out  pixel, header or error     kind, code, rgb, address, size, last
//  cfg         in   file size limit write      file_size_limit
//
// One byte is taken per cycle in header, skip, pixel, pad and idle phases when not stalled.
// After a raw-size byte that passes its own check the input holds off during the area
// multiply, need compute, raw check, 32-step radix-2 padding divider and header push, or
// during multiply, need compute, raw check and error push when raw size < width*height*3.
// Synchronous rst clears phase, counters and the file size limit to its default.
// byte_in.ready drops while both output buffer entries hold words.
`timescale 1ns / 1ps
module bmp24_stream_decoder_top import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic         clk,
  input logic         rst,
  bmpd_in_if.sink     byte_in,
  bmpd_out_if.source  result_out,
  bmpd_cfg_if.sink    cfg
);

  bmpd_cmd_t    cmd;
  bmpd_stat_t   stat;
  bmpd_result_t result;
  logic         obuf_full;

  assign cfg.ready = 1'b1;

  bmpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_first  (byte_in.first_byte),
    .in_ready  (byte_in.ready),
    .obuf_full (obuf_full),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmpd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (byte_in.data_byte),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.file_size_limit),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  bmpd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd.push),
    .push_data (result),
    .full      (obuf_full),
    .out       (result_out)
  );

endmodule

// ===== rtl/bmpd_checker.sv =====
// Port-level checker for the BMP stream decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmpd_checker import bmpd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic [KIND_W-1:0] result_kind,
  input logic [ERR_W-1:0]  error_code,
  input logic [RGB_W-1:0]  pixel_rgb,
  input logic [ADDR_W-1:0] pixel_address,
  input logic [DIM_W-1:0]  out_width,
  input logic [DIM_W-1:0]  out_height,
  input logic              last_pixel
);

  `ASSERT_NEXT(a_stall_hold, clk, rst, (!rst && valid && !ready), (valid && $stable(result_kind) && $stable(pixel_rgb) && $stable(pixel_address)), "result word changed while stalled")
  `ASSERT_IMPLY(a_err_word, clk, rst, (valid && result_kind == KIND_ERROR), (error_code != ERR_NONE && pixel_rgb == '0 && pixel_address == '0 && out_width == '0 && out_height == '0 && !last_pixel), "malformed error word")
  `ASSERT_IMPLY(a_hdr_word, clk, rst, (valid && result_kind == KIND_HEADER), (error_code == ERR_NONE && out_width != '0 && out_height != '0 && pixel_rgb == '0 && !last_pixel), "malformed header word")
  `ASSERT_IMPLY(a_pix_word, clk, rst, (valid && result_kind == KIND_PIXEL), (error_code == ERR_NONE && out_width == '0 && out_height == '0), "malformed pixel word")

endmodule

bind bmp24_stream_decoder_top bmpd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result_out.valid),
  .ready         (result_out.ready),
  .result_kind   (result_out.result_kind),
  .error_code    (result_out.error_code),
  .pixel_rgb     (result_out.pixel_rgb),
  .pixel_address (result_out.pixel_address),
  .out_width     (result_out.out_width),
  .out_height    (result_out.out_height),
  .last_pixel    (result_out.last_pixel)
);
